FILE: hw/rtl/held_note_qualifier_top_macros.svh
// Assertion macros for the held note qualifier.
`ifndef HELD_NOTE_QUALIFIER_TOP_MACROS_SVH
`define HELD_NOTE_QUALIFIER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HNQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("held note qualifier assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HNQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("held note qualifier assertion failed");

`endif

FILE: hw/rtl/hnq_pkg.sv
// Package with the types, codes and helper functions of the held note qualifier.
`timescale 1ns / 1ps
package hnq_pkg;

  typedef enum logic [2:0] {
    PH_INIT        = 3'd0,
    PH_INIT_SILENT = 3'd1,
    PH_INIT_OTHER  = 3'd2,
    PH_DETECTING   = 3'd3,
    PH_INTERMED    = 3'd4,
    PH_COMPLETE    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    V_NONE     = 3'd0,
    V_DET      = 3'd1,
    V_DET_NEXT = 3'd2,
    V_INV      = 3'd3,
    V_INV_NEXT = 3'd4
  } verdict_e;

  localparam logic [1:0] CFG_TARGET_NOTE = 2'd0;
  localparam logic [1:0] CFG_MIN_HOLD    = 2'd1;
  localparam logic [1:0] CFG_MAX_GAP     = 2'd2;

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] note_value;
    logic [31:0] now_ms;
  } hnq_item_t;

  typedef struct packed {
    logic [3:0]  target_note;
    logic [15:0] min_hold_ms;
    logic [15:0] max_gap_ms;
  } hnq_cfg_t;

  typedef struct packed {
    logic [2:0] verdict;
    logic       finished;
  } hnq_res_t;

  // Note number modulo twelve: n = 4q + r, so n mod 12 = 4 (q mod 3) + r.
  // q mod 3 is the sum of its base-four digits, folded down.
  function automatic logic [3:0] pitch_class(input logic [15:0] n);
    logic [4:0] s1;
    logic [2:0] s2;
    logic [2:0] s3;
    logic [1:0] r;
    s1 = '0;
    for (int i = 1; i < 8; i++) begin
      s1 = s1 + 5'(n[2*i +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    r  = (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
    return {r, n[1:0]};
  endfunction

  // Register value reduced modulo twelve.
  function automatic logic [3:0] target_class(input logic [3:0] t);
    return (t >= 4'd12) ? 4'(t - 4'd12) : t;
  endfunction

endpackage

FILE: hw/rtl/hnq_if.sv
// Stream interfaces for the input items and the results of the held note qualifier.
`timescale 1ns / 1ps
interface hnq_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] note_value;
  logic [31:0] now_ms;

  modport source (output valid, output cmd, output note_value, output now_ms, input ready);
  modport sink   (input valid, input cmd, input note_value, input now_ms, output ready);
endinterface

interface hnq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  logic       finished;

  modport source (output valid, output verdict, output finished, input ready);
  modport sink   (input valid, input verdict, input finished, output ready);
endinterface

FILE: hw/rtl/hnq_core.sv
// Phase machine of the held note qualifier: state registers and the per-item update.
`timescale 1ns / 1ps
module hnq_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  hnq_pkg::hnq_item_t item_i,
  input  hnq_pkg::hnq_cfg_t  cfg_i,
  output hnq_pkg::hnq_res_t  res_o
);

  hnq_pkg::phase_e phase_q, phase_d;
  logic [31:0]     entered_q, entered_d;
  logic [31:0]     hold_q, hold_d;

  logic [31:0] dwell;
  logic [31:0] held;
  logic [31:0] limit;
  logic        silent;
  logic        is_tgt;
  logic [2:0]  verdict;

  assign dwell  = item_i.now_ms - entered_q;
  assign held   = item_i.now_ms - hold_q;
  assign silent = (item_i.note_value == 16'd0);
  assign is_tgt = !silent && (hnq_pkg::pitch_class(item_i.note_value) ==
                              hnq_pkg::target_class(cfg_i.target_note));
  // Twice the minimum hold is kept at 17 bits.
  assign limit  = (phase_q == hnq_pkg::PH_INIT_SILENT) ?
                  {15'd0, cfg_i.min_hold_ms, 1'b0} : {16'd0, cfg_i.max_gap_ms};

  always_comb begin
    phase_d   = phase_q;
    entered_d = entered_q;
    hold_d    = hold_q;
    verdict   = hnq_pkg::V_NONE;
    if (item_i.cmd == hnq_pkg::CMD_RESTART) begin
      phase_d   = hnq_pkg::PH_INIT;
      entered_d = '0;
      hold_d    = '0;
    end else begin
      unique case (phase_q)
        hnq_pkg::PH_INIT: begin
          entered_d = item_i.now_ms;
          if (silent) begin
            phase_d = hnq_pkg::PH_INIT_SILENT;
          end else if (is_tgt) begin
            phase_d = hnq_pkg::PH_DETECTING;
            hold_d  = item_i.now_ms;
          end else begin
            phase_d = hnq_pkg::PH_INIT_OTHER;
          end
        end
        hnq_pkg::PH_INIT_SILENT, hnq_pkg::PH_INIT_OTHER: begin
          if (limit < dwell) begin
            phase_d   = hnq_pkg::PH_COMPLETE;
            entered_d = item_i.now_ms;
            verdict   = silent ? hnq_pkg::V_INV : hnq_pkg::V_INV_NEXT;
          end else if (is_tgt) begin
            phase_d   = hnq_pkg::PH_DETECTING;
            entered_d = item_i.now_ms;
            hold_d    = item_i.now_ms;
          end
        end
        hnq_pkg::PH_DETECTING: begin
          if (!is_tgt) begin
            phase_d   = hnq_pkg::PH_INTERMED;
            entered_d = item_i.now_ms;
          end
        end
        hnq_pkg::PH_INTERMED: begin
          if ({16'd0, cfg_i.max_gap_ms} < dwell) begin
            phase_d   = hnq_pkg::PH_COMPLETE;
            entered_d = item_i.now_ms;
            if ({16'd0, cfg_i.min_hold_ms} < held) begin
              verdict = silent ? hnq_pkg::V_DET : hnq_pkg::V_DET_NEXT;
            end else begin
              verdict = silent ? hnq_pkg::V_INV : hnq_pkg::V_INV_NEXT;
            end
          end else if (is_tgt) begin
            // Re-entry keeps the original hold start.
            phase_d   = hnq_pkg::PH_DETECTING;
            entered_d = item_i.now_ms;
          end
        end
        default: begin
          verdict = hnq_pkg::V_DET;
        end
      endcase
    end
  end

  assign res_o.verdict  = verdict;
  assign res_o.finished = (phase_d >= hnq_pkg::PH_COMPLETE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= hnq_pkg::PH_INIT;
      entered_q <= '0;
      hold_q    <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      entered_q <= entered_d;
      hold_q    <= hold_d;
    end
  end

endmodule

FILE: hw/rtl/held_note_qualifier_top.sv
// Top level of the held note qualifier: channels, configuration registers and pipeline.
//
// Input items arrive on in_if (cmd, note_value, now_ms) and results leave on
// out_if (verdict, finished); both are valid/ready channels and a transfer
// happens at a rising edge with valid and ready high. Every input transfer
// yields exactly one result transfer, in order.
// The configuration registers (target note, minimum hold, maximum gap) are
// written through cfg_we_i, cfg_idx_i and cfg_wdata_i, one register per edge;
// they should only change while no item is in flight.
// An accepted item sits in the input register, the phase update is done
// combinationally from there, and the result register drives out_if.
// Throughput is one item per cycle while the receiver does not stall.
// When the receiver stalls, the result is held and the input register can
// still take one more item; after that in_if.ready drops until the result
// is transferred. Reset empties both registers, clears the configuration to
// zero and returns the phase machine to its initial phase.
`timescale 1ns / 1ps
`include "held_note_qualifier_top_macros.svh"
module held_note_qualifier_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  hnq_in_if.sink      in_if,
  hnq_out_if.source   out_if,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  // Configuration registers.
  hnq_pkg::hnq_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hnq_pkg::CFG_TARGET_NOTE: cfg_q.target_note <= cfg_wdata_i[3:0];
        hnq_pkg::CFG_MIN_HOLD:    cfg_q.min_hold_ms <= cfg_wdata_i;
        hnq_pkg::CFG_MAX_GAP:     cfg_q.max_gap_ms  <= cfg_wdata_i;
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // Input register stage.
  hnq_pkg::hnq_item_t item_q;
  logic               item_vld_q;
  logic               advance;
  logic               in_fire;

  // The result register is free when empty or when its result leaves now.
  assign advance     = item_vld_q && (!out_if.valid || out_if.ready);
  assign in_if.ready = !item_vld_q || advance;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      item_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.cmd        <= in_if.cmd;
      item_q.note_value <= in_if.note_value;
      item_q.now_ms     <= in_if.now_ms;
    end
  end

  // Phase update: the state moves on exactly when the item passes to the
  // result register.
  hnq_pkg::hnq_res_t res_d;

  hnq_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // Result register stage.
  hnq_pkg::hnq_res_t res_q;
  logic              out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_if.ready) begin
      out_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid    = out_vld_q;
  assign out_if.verdict  = res_q.verdict;
  assign out_if.finished = res_q.finished;

  // A verdict other than none is given exactly when the machine is complete.
  `HNQ_ASSERT_IMPL(a_verdict_matches_finished, out_vld_q,
                   out_if.finished == (out_if.verdict != hnq_pkg::V_NONE))
  // A waiting item is not dropped while the receiver stalls.
  `HNQ_ASSERT_NEXT(a_item_kept_on_stall, item_vld_q && out_vld_q && !out_if.ready,
                   item_vld_q)
  // An item that moves on always lands in the result register.
  `HNQ_ASSERT_NEXT(a_advance_fills_result, advance, out_vld_q)

endmodule
